FILE: sv/sps_pkg.sv
// Shared constants for the matrix saddle point search block.
package sps_pkg;

  localparam int MaxDimDefault = 16;
  localparam int ValueW        = 32;
  localparam int IdxW          = 4;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 5;

  localparam logic [CfgIdxW-1:0] RegRowCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegColCount = CfgIdxW'(1);

endpackage

FILE: sv/sps_mem.sv
// Matrix store: one write port, one read port with registered read data.
module sps_mem #(
  parameter int Depth = 256,
  parameter int DataW = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sps_search.sv
// Search sequencer: walks the stored matrix row by row and issues results.
module sps_search
  import sps_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault,
  parameter int DimW    = $clog2(MAX_DIM),
  parameter int AddrW   = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DimW-1:0]   last_row_i,
  input  logic [DimW-1:0]   last_col_i,
  output logic              busy_o,
  output logic [AddrW-1:0]  rd_addr_o,
  input  logic [ValueW-1:0] rd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ValueW-1:0] value_o,
  output logic [IdxW-1:0]   row_index_o,
  output logic [IdxW-1:0]   col_index_o,
  output logic              last_o
);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SMin   = 5'b00010,
    SCol   = 5'b00100,
    SEmit  = 5'b01000,
    SFinal = 5'b10000
  } sps_state_e;

  sps_state_e state_q, state_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [DimW-1:0]   j_q, j_d;
  logic              iss_done_q, iss_done_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_first_q, rd_first_d;
  logic              rd_end_q, rd_end_d;
  logic [DimW-1:0]   rd_col_q, rd_col_d;
  logic [ValueW-1:0] minv_q, minv_d;
  logic [DimW-1:0]   mcol_q, mcol_d;
  logic              ok_q, ok_d;
  logic              pend_q, pend_d;
  logic [ValueW-1:0] pend_val_q, pend_val_d;
  logic [DimW-1:0]   pend_row_q, pend_row_d;
  logic [DimW-1:0]   pend_col_q, pend_col_d;
  logic              out_vld_q, out_vld_d;
  logic              out_found_q, out_found_d;
  logic [ValueW-1:0] out_val_q, out_val_d;
  logic [IdxW-1:0]   out_row_q, out_row_d;
  logic [IdxW-1:0]   out_col_q, out_col_d;
  logic              out_last_q, out_last_d;

  logic            out_free;
  logic            issue;
  logic [DimW-1:0] end_idx;
  logic [DimW-1:0] rd_row;
  logic [DimW-1:0] rd_col;

  assign out_free = !out_vld_q || out_ready_i;
  assign issue    = ((state_q == SMin) || (state_q == SCol)) && !iss_done_q;
  assign end_idx  = (state_q == SMin) ? last_col_i : last_row_i;
  assign rd_row   = (state_q == SCol) ? j_q : row_q;
  assign rd_col   = (state_q == SCol) ? mcol_q : j_q;
  assign rd_addr_o = AddrW'(rd_row) * AddrW'(MAX_DIM) + AddrW'(rd_col);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    j_d        = j_q;
    iss_done_d = iss_done_q;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    rd_end_d   = 1'b0;
    rd_col_d   = rd_col_q;
    minv_d     = minv_q;
    mcol_d     = mcol_q;
    ok_d       = ok_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    pend_row_d = pend_row_q;
    pend_col_d = pend_col_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_found_d = out_found_q;
    out_val_d  = out_val_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_last_d = out_last_q;

    if (issue) begin
      rd_vld_d   = 1'b1;
      rd_first_d = (j_q == '0);
      rd_end_d   = (j_q == end_idx);
      rd_col_d   = j_q;
      if (j_q == end_idx) begin
        iss_done_d = 1'b1;
      end else begin
        j_d = j_q + DimW'(1);
      end
    end

    case (state_q)
      SIdle: begin
        if (start_i) begin
          row_d      = '0;
          j_d        = '0;
          iss_done_d = 1'b0;
          pend_d     = 1'b0;
          state_d    = SMin;
        end
      end
      SMin: begin
        if (rd_vld_q) begin
          if (rd_first_q || ($signed(rd_data_i) < $signed(minv_q))) begin
            minv_d = rd_data_i;
            mcol_d = rd_col_q;
          end
          if (rd_end_q) begin
            state_d    = SCol;
            j_d        = '0;
            iss_done_d = 1'b0;
            ok_d       = 1'b1;
          end
        end
      end
      SCol: begin
        if (rd_vld_q) begin
          if ($signed(minv_q) < $signed(rd_data_i)) begin
            ok_d = 1'b0;
          end
          if (rd_end_q) begin
            state_d = SEmit;
          end
        end
      end
      SEmit: begin
        if (!(ok_q && pend_q && !out_free)) begin
          if (ok_q) begin
            if (pend_q) begin
              out_vld_d   = 1'b1;
              out_found_d = 1'b1;
              out_val_d   = pend_val_q;
              out_row_d   = IdxW'(pend_row_q);
              out_col_d   = IdxW'(pend_col_q);
              out_last_d  = 1'b0;
            end
            pend_d     = 1'b1;
            pend_val_d = minv_q;
            pend_row_d = row_q;
            pend_col_d = mcol_q;
          end
          if (row_q == last_row_i) begin
            state_d = SFinal;
          end else begin
            row_d      = row_q + DimW'(1);
            j_d        = '0;
            iss_done_d = 1'b0;
            state_d    = SMin;
          end
        end
      end
      SFinal: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_found_d = pend_q;
          out_val_d   = pend_q ? pend_val_q : '0;
          out_row_d   = pend_q ? IdxW'(pend_row_q) : '0;
          out_col_d   = pend_q ? IdxW'(pend_col_q) : '0;
          out_last_d  = 1'b1;
          pend_d      = 1'b0;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      row_q      <= '0;
      j_q        <= '0;
      iss_done_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      j_q        <= j_d;
      iss_done_q <= iss_done_d;
      rd_vld_q   <= rd_vld_d;
      pend_q     <= pend_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q  <= rd_first_d;
    rd_end_q    <= rd_end_d;
    rd_col_q    <= rd_col_d;
    minv_q      <= minv_d;
    mcol_q      <= mcol_d;
    ok_q        <= ok_d;
    pend_val_q  <= pend_val_d;
    pend_row_q  <= pend_row_d;
    pend_col_q  <= pend_col_d;
    out_found_q <= out_found_d;
    out_val_q   <= out_val_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_last_q  <= out_last_d;
  end

  assign busy_o      = (state_q != SIdle);
  assign out_valid_o = out_vld_q;
  assign found_o     = out_found_q;
  assign value_o     = out_val_q;
  assign row_index_o = out_row_q;
  assign col_index_o = out_col_q;
  assign last_o      = out_last_q;

endmodule

FILE: sv/matrix_saddle_point_finder_core.sv
// Top level of the matrix saddle point search block.
//
// Usage: set the row and column counts through the configuration channel
// (index 0 is the row count, index 1 the column count; zero counts as one and
// values above MAX_DIM count as MAX_DIM). Any configuration beat discards a
// partly loaded matrix. Matrix elements then arrive on the input channel in
// row-major order, one beat per cycle while loading and no configuration beat is offered.
// After the final element the block walks the stored matrix through the
// single read port of its store: for each row it reads the row for its
// minimum, then the column of that minimum. The input and configuration
// channels are held off until the search is over. A configuration beat
// offered in the same cycle as an input beat is taken first.
// Each saddle row gives one output beat; if there is none, one beat with
// found clear is given. The final beat has last set.
// Results sit in an output register; when the receiver stalls, the search
// waits on its next result but the following matrix may still be loaded once
// the search is over. Reset restores counts of one, empties the output
// register and restarts loading; the store itself is not cleared.
module matrix_saddle_point_finder_core
  import sps_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ValueW-1:0]   element_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [ValueW-1:0]   value_o,
  output logic [IdxW-1:0]     row_index_o,
  output logic [IdxW-1:0]     col_index_o,
  output logic                last_o
);

  localparam int DimW  = $clog2(MAX_DIM);
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM);

  logic [CfgDataW-1:0] rows_cfg_q, rows_cfg_d;
  logic [CfgDataW-1:0] cols_cfg_q, cols_cfg_d;
  logic [DimW-1:0]     ld_row_q, ld_row_d;
  logic [DimW-1:0]     ld_col_q, ld_col_d;
  logic [DimW-1:0]     last_row, last_col;
  logic [31:0]         rows_ext, cols_ext;
  logic                cfg_acc, in_acc, final_elem, busy;
  logic [AddrW-1:0]    waddr, raddr;
  logic [ValueW-1:0]   rdata;

  assign rows_ext = 32'(rows_cfg_q);
  assign cols_ext = 32'(cols_cfg_q);

  always_comb begin
    if (rows_ext == 32'd0) begin
      last_row = '0;
    end else if (rows_ext > 32'(MAX_DIM)) begin
      last_row = DimW'(MAX_DIM - 1);
    end else begin
      last_row = DimW'(rows_ext - 32'd1);
    end
    if (cols_ext == 32'd0) begin
      last_col = '0;
    end else if (cols_ext > 32'(MAX_DIM)) begin
      last_col = DimW'(MAX_DIM - 1);
    end else begin
      last_col = DimW'(cols_ext - 32'd1);
    end
  end

  assign cfg_ready_o = !busy;
  assign in_ready_o  = !busy && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign final_elem  = (ld_row_q == last_row) && (ld_col_q == last_col);
  assign waddr       = AddrW'(ld_row_q) * AddrW'(MAX_DIM) + AddrW'(ld_col_q);

  always_comb begin
    rows_cfg_d = rows_cfg_q;
    cols_cfg_d = cols_cfg_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    if (cfg_acc) begin
      if (cfg_index_i == RegRowCount) begin
        rows_cfg_d = cfg_data_i;
      end else if (cfg_index_i == RegColCount) begin
        cols_cfg_d = cfg_data_i;
      end
      ld_row_d = '0;
      ld_col_d = '0;
    end else if (in_acc) begin
      if (ld_col_q == last_col) begin
        ld_col_d = '0;
        ld_row_d = (ld_row_q == last_row) ? '0 : ld_row_q + DimW'(1);
      end else begin
        ld_col_d = ld_col_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CfgDataW'(1);
      cols_cfg_q <= CfgDataW'(1);
      ld_row_q   <= '0;
      ld_col_q   <= '0;
    end else begin
      rows_cfg_q <= rows_cfg_d;
      cols_cfg_q <= cols_cfg_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
    end
  end

  sps_mem #(
    .Depth(MAX_DIM * MAX_DIM),
    .DataW(ValueW),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(waddr),
    .wdata_i(element_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sps_search #(
    .MAX_DIM(MAX_DIM),
    .DimW   (DimW),
    .AddrW  (AddrW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && final_elem),
    .last_row_i (last_row),
    .last_col_i (last_col),
    .busy_o     (busy),
    .rd_addr_o  (raddr),
    .rd_data_i  (rdata),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .value_o    (value_o),
    .row_index_o(row_index_o),
    .col_index_o(col_index_o),
    .last_o     (last_o)
  );

endmodule

FILE: sv/sps_checker.sv
// Port-level checks for the saddle point search block, bound to the top level.
module sps_checker
  import sps_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              found_o,
  input logic [ValueW-1:0] value_o,
  input logic [IdxW-1:0]   row_index_o,
  input logic [IdxW-1:0]   col_index_o,
  input logic              last_o
);

  // An output beat that is not taken must stay, with its value, found and last unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
      $stable(found_o) && $stable(last_o))
    else $error("output beat dropped or changed while stalled");

  // A beat reporting no saddle point must close the matrix.
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o)
    else $error("no-saddle beat without last");

  // A beat reporting no saddle point carries zero payload.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> value_o == '0 && row_index_o == '0 &&
      col_index_o == '0)
    else $error("no-saddle beat with non-zero payload");

  // A configuration beat and an input beat are never taken in the same cycle.
  a_cfg_in_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && in_valid_i && in_ready_o))
    else $error("configuration and input beats taken together");

endmodule

bind matrix_saddle_point_finder_core sps_checker u_sps_checker (.*);
